// File: rtl/ptme_pkg.sv
`timescale 1ns / 1ps

package ptme_pkg;

   // Table geometry: 512 entries per table page, 9-bit level index.
   localparam int IDX_W         = 9;
   localparam int ENTRIES       = 512;
   localparam int FRAME_W       = 44;
   localparam int PERM_W        = 5;
   localparam int VPN_W         = 27;
   localparam int ENTRY_W       = 50;
   localparam int POOL_PAGES_DEF = 64;

   // Request operation codes.
   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_MAP    = 2'd1,
      OP_UNMAP  = 2'd2,
      OP_FLUSH  = 2'd3
   } op_type;

   // Response status codes.
   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_NOT_MAPPED = 2'd1,
      ST_NO_MEMORY  = 2'd2
   } status_type;

   // Controller states.
   typedef enum logic [4:0] {
      S_INIT,
      S_IDLE,
      S_RD0,
      S_L0,
      S_RD1,
      S_L1,
      S_RD2,
      S_L2,
      S_LEAF_WR,
      S_AL_SCAN,
      S_AL_CLR,
      S_AL_LINK,
      S_SC_RD,
      S_SC_CHK,
      S_FL_RD,
      S_FL_CHK,
      S_FL_MRD,
      S_FL_MCHK,
      S_FL_END,
      S_DONE
   } state_type;

   // Table memory address selection: which page and which index.
   typedef enum logic [2:0] {
      A_ROOT_I0,
      A_T1_I1,
      A_T2_I2,
      A_ROOT_CNT,
      A_T1_CNT,
      A_T2_CNT,
      A_ROOT_AUX
   } asel_type;

   // Table memory write data selection.
   typedef enum logic [1:0] {
      W_ZERO,
      W_PTR_T1,
      W_PTR_T2,
      W_LEAF
   } wsel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       req_ready;
      logic       rd;
      logic       wr;
      asel_type   asel;
      wsel_type   wsel;
      logic       load_t1;
      logic       alloc_t1;
      logic       alloc_t2;
      logic       free_t1;
      logic       free_t2;
      logic       free_child;
      logic       load_t2;
      logic       cnt_clr;
      logic       cnt_inc;
      logic       aux_inc;
      logic       pg_clr;
      logic       pg_inc;
      logic       rsp_load;
      status_type rsp_status;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic   req_valid;
      op_type op;
      logic   ptr_ok;
      logic   entry_valid;
      logic   page_free;
      logic   pg_last;
      logic   cnt_last;
      logic   aux_last;
      logic   slot_free;
   } stat_type;

endpackage

// File: rtl/ptme_if.sv
`timescale 1ns / 1ps

// Request channel: one table operation per transaction.
interface ptme_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [26:0] vpn;
   logic [43:0] frame;
   logic [4:0]  perms;

   modport source (output valid, output op, output vpn, output frame, output perms,
                   input ready);
   modport sink (input valid, input op, input vpn, input frame, input perms,
                 output ready);
endinterface

// Response channel: one result per request.
interface ptme_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        mapped;
   logic [43:0] frame_out;
   logic [4:0]  perms_out;

   modport source (output valid, output status, output mapped, output frame_out,
                   output perms_out, input ready);
   modport sink (input valid, input status, input mapped, input frame_out,
                 input perms_out, output ready);
endinterface

// File: rtl/ptme_ctrl.sv
`timescale 1ns / 1ps

module ptme_ctrl
   import ptme_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type  state_ff, state_in;
   status_type code_ff, code_in;
   logic       lvl2_ff, lvl2_in;
   logic       fresh_ff, fresh_in;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         code_ff  <= ST_OK;
         lvl2_ff  <= 1'b0;
         fresh_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
         lvl2_ff  <= lvl2_in;
         fresh_ff <= fresh_in;
      end
   end

   // Next state, result code and walk level.
   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      lvl2_in  = lvl2_ff;
      fresh_in = fresh_ff;
      unique case (state_ff)
         S_INIT: if (stat.cnt_last) state_in = S_IDLE;
         S_IDLE: begin
            if (stat.req_valid) begin
               state_in = S_RD0;
               lvl2_in  = 1'b0;
               fresh_in = 1'b0;
            end
         end
         S_RD0: state_in = S_L0;
         S_L0: begin
            if (stat.op == OP_FLUSH) begin
               state_in = S_FL_RD;
            end else if (stat.ptr_ok) begin
               state_in = S_RD1;
            end else if (stat.op == OP_MAP) begin
               state_in = S_AL_SCAN;
               lvl2_in  = 1'b0;
            end else begin
               state_in = S_DONE;
               code_in  = ST_NOT_MAPPED;
            end
         end
         S_RD1: state_in = S_L1;
         S_L1: begin
            if (stat.ptr_ok) begin
               state_in = (stat.op == OP_MAP) ? S_LEAF_WR : S_RD2;
            end else if (stat.op == OP_MAP) begin
               state_in = S_AL_SCAN;
               lvl2_in  = 1'b1;
            end else begin
               state_in = S_DONE;
               code_in  = ST_NOT_MAPPED;
            end
         end
         S_RD2: state_in = S_L2;
         S_L2: begin
            if (!stat.entry_valid) begin
               state_in = S_DONE;
               code_in  = ST_NOT_MAPPED;
            end else if (stat.op == OP_LOOKUP) begin
               state_in = S_DONE;
               code_in  = ST_OK;
            end else begin
               state_in = S_SC_RD;
               lvl2_in  = 1'b1;
            end
         end
         S_LEAF_WR: begin
            state_in = S_DONE;
            code_in  = ST_OK;
         end
         S_AL_SCAN: begin
            if (stat.page_free) begin
               state_in = S_AL_CLR;
               if (!lvl2_ff) fresh_in = 1'b1;
            end else if (stat.pg_last) begin
               state_in = S_DONE;
               code_in  = ST_NO_MEMORY;
            end
         end
         S_AL_CLR: if (stat.cnt_last) state_in = S_AL_LINK;
         S_AL_LINK: begin
            if (lvl2_ff) begin
               state_in = S_LEAF_WR;
            end else begin
               state_in = S_AL_SCAN;
               lvl2_in  = 1'b1;
            end
         end
         S_SC_RD: state_in = S_SC_CHK;
         S_SC_CHK: begin
            if (stat.entry_valid) begin
               state_in = S_DONE;
               code_in  = ST_OK;
            end else if (stat.cnt_last) begin
               if (lvl2_ff) begin
                  state_in = S_SC_RD;
                  lvl2_in  = 1'b0;
               end else begin
                  state_in = S_DONE;
                  code_in  = ST_OK;
               end
            end else begin
               state_in = S_SC_RD;
            end
         end
         S_FL_RD: state_in = S_FL_CHK;
         S_FL_CHK: begin
            if (stat.ptr_ok) begin
               state_in = S_FL_MRD;
            end else if (stat.aux_last) begin
               state_in = S_DONE;
               code_in  = ST_OK;
            end else begin
               state_in = S_FL_RD;
            end
         end
         S_FL_MRD: state_in = S_FL_MCHK;
         S_FL_MCHK: state_in = stat.cnt_last ? S_FL_END : S_FL_MRD;
         S_FL_END: begin
            if (stat.aux_last) begin
               state_in = S_DONE;
               code_in  = ST_OK;
            end else begin
               state_in = S_FL_RD;
            end
         end
         S_DONE: if (stat.slot_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath commands.
   always_comb begin
      cmd = '0;
      cmd.asel = A_ROOT_I0;
      cmd.wsel = W_ZERO;
      cmd.rsp_status = code_ff;
      unique case (state_ff)
         S_INIT: begin
            cmd.wr      = 1'b1;
            cmd.asel    = A_ROOT_CNT;
            cmd.cnt_inc = 1'b1;
         end
         S_IDLE: cmd.req_ready = 1'b1;
         S_RD0: begin
            cmd.rd   = 1'b1;
            cmd.asel = A_ROOT_I0;
         end
         S_L0: begin
            cmd.load_t1 = 1'b1;
            if (stat.op != OP_FLUSH && !stat.ptr_ok && stat.op == OP_MAP) cmd.pg_clr = 1'b1;
         end
         S_RD1: begin
            cmd.rd   = 1'b1;
            cmd.asel = A_T1_I1;
         end
         S_L1: begin
            cmd.load_t2 = 1'b1;
            if (!stat.ptr_ok && stat.op == OP_MAP) cmd.pg_clr = 1'b1;
         end
         S_RD2: begin
            cmd.rd   = 1'b1;
            cmd.asel = A_T2_I2;
         end
         S_L2: begin
            if (stat.entry_valid && stat.op != OP_LOOKUP) begin
               cmd.wr      = 1'b1;
               cmd.asel    = A_T2_I2;
               cmd.cnt_clr = 1'b1;
            end
         end
         S_LEAF_WR: begin
            cmd.wr   = 1'b1;
            cmd.asel = A_T2_I2;
            cmd.wsel = W_LEAF;
         end
         S_AL_SCAN: begin
            if (stat.page_free) begin
               cmd.alloc_t1 = !lvl2_ff;
               cmd.alloc_t2 = lvl2_ff;
               cmd.cnt_clr  = 1'b1;
            end else if (stat.pg_last) begin
               // Give back a middle table taken by this same request.
               if (lvl2_ff && fresh_ff) begin
                  cmd.wr      = 1'b1;
                  cmd.asel    = A_ROOT_I0;
                  cmd.free_t1 = 1'b1;
               end
            end else begin
               cmd.pg_inc = 1'b1;
            end
         end
         S_AL_CLR: begin
            cmd.wr      = 1'b1;
            cmd.asel    = lvl2_ff ? A_T2_CNT : A_T1_CNT;
            cmd.cnt_inc = 1'b1;
         end
         S_AL_LINK: begin
            cmd.wr = 1'b1;
            if (lvl2_ff) begin
               cmd.asel = A_T1_I1;
               cmd.wsel = W_PTR_T2;
            end else begin
               cmd.asel   = A_ROOT_I0;
               cmd.wsel   = W_PTR_T1;
               cmd.pg_clr = 1'b1;
            end
         end
         S_SC_RD: begin
            cmd.rd   = 1'b1;
            cmd.asel = lvl2_ff ? A_T2_CNT : A_T1_CNT;
         end
         S_SC_CHK: begin
            if (!stat.entry_valid) begin
               if (stat.cnt_last) begin
                  cmd.wr = 1'b1;
                  if (lvl2_ff) begin
                     cmd.free_t2 = 1'b1;
                     cmd.asel    = A_T1_I1;
                     cmd.cnt_clr = 1'b1;
                  end else begin
                     cmd.free_t1 = 1'b1;
                     cmd.asel    = A_ROOT_I0;
                  end
               end else begin
                  cmd.cnt_inc = 1'b1;
               end
            end
         end
         S_FL_RD: begin
            cmd.rd   = 1'b1;
            cmd.asel = A_ROOT_AUX;
         end
         S_FL_CHK: begin
            if (stat.ptr_ok) begin
               cmd.load_t1 = 1'b1;
               cmd.cnt_clr = 1'b1;
            end else begin
               cmd.wr      = 1'b1;
               cmd.asel    = A_ROOT_AUX;
               cmd.aux_inc = 1'b1;
            end
         end
         S_FL_MRD: begin
            cmd.rd   = 1'b1;
            cmd.asel = A_T1_CNT;
         end
         S_FL_MCHK: begin
            cmd.free_child = 1'b1;
            cmd.cnt_inc    = 1'b1;
         end
         S_FL_END: begin
            cmd.free_t1 = 1'b1;
            cmd.wr      = 1'b1;
            cmd.asel    = A_ROOT_AUX;
            cmd.aux_inc = 1'b1;
         end
         S_DONE: cmd.rsp_load = stat.slot_free;
         default: cmd.req_ready = 1'b0;
      endcase
   end

   // A finished transaction leaves as soon as the output slot is free.
   a_done_leaves: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && stat.slot_free) |=> state_ff == S_IDLE)
      else $error("response not released from done state");

   // A lookup or unmap that hits an invalid leaf reports not mapped.
   a_leaf_miss: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_L2 && !stat.entry_valid)
      |=> (state_ff == S_DONE && code_ff == ST_NOT_MAPPED))
      else $error("invalid leaf not reported");

   // A free page found by the scan is cleared next.
   a_alloc_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_AL_SCAN && stat.page_free) |=> state_ff == S_AL_CLR)
      else $error("allocated page not cleared");

endmodule

// File: rtl/ptme_dp.sv
`timescale 1ns / 1ps

module ptme_dp
   import ptme_pkg::*;
#(
   parameter int POOL_PAGES = POOL_PAGES_DEF
)
(
   input  logic     clock,
   input  logic     reset,
   input  cmd_type  cmd,
   output stat_type stat,
   ptme_req_if.sink   req_ch,
   ptme_rsp_if.source rsp_ch
);

   localparam int PAGE_W = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
   localparam int ADDR_W = PAGE_W + IDX_W;
   localparam int DEPTH  = POOL_PAGES * ENTRIES;

   logic [ENTRY_W-1:0]    mem [0:DEPTH-1];
   logic [ENTRY_W-1:0]    rd_data_ff;
   logic [ADDR_W-1:0]     addr;
   logic [ENTRY_W-1:0]    wdata;

   op_type                op_ff;
   logic [VPN_W-1:0]      vpn_ff;
   logic [FRAME_W-1:0]    frame_ff;
   logic [PERM_W-1:0]     perms_ff;
   logic [PAGE_W-1:0]     t1_ff, t2_ff, pg_ff;
   logic [IDX_W-1:0]      cnt_ff, aux_ff;
   logic [POOL_PAGES-1:0] used_ff, used_in;

   logic                  rsp_valid_ff;
   status_type            rsp_status_ff;
   logic                  rsp_mapped_ff;
   logic [FRAME_W-1:0]    rsp_frame_ff;
   logic [PERM_W-1:0]     rsp_perms_ff;

   logic [FRAME_W-1:0]    rd_frame;
   logic [PAGE_W-1:0]     ptr_page;
   logic                  ptr_ok;
   logic                  req_fire;

   assign req_fire = req_ch.valid && cmd.req_ready;
   assign rd_frame = rd_data_ff[ENTRY_W-1:PERM_W+1];
   assign ptr_page = rd_frame[PAGE_W-1:0];
   // A next-table pointer is usable only inside the pool and not at the root.
   assign ptr_ok   = rd_data_ff[0] && (rd_frame != '0)
                     && (rd_frame < FRAME_W'(POOL_PAGES));

   // Memory address: page and index from the selected sources.
   always_comb begin
      unique case (cmd.asel)
         A_ROOT_I0:  addr = {PAGE_W'(0), vpn_ff[3*IDX_W-1:2*IDX_W]};
         A_T1_I1:    addr = {t1_ff, vpn_ff[2*IDX_W-1:IDX_W]};
         A_T2_I2:    addr = {t2_ff, vpn_ff[IDX_W-1:0]};
         A_ROOT_CNT: addr = {PAGE_W'(0), cnt_ff};
         A_T1_CNT:   addr = {t1_ff, cnt_ff};
         A_T2_CNT:   addr = {t2_ff, cnt_ff};
         A_ROOT_AUX: addr = {PAGE_W'(0), aux_ff};
         default:    addr = '0;
      endcase
   end

   // Memory write data.
   always_comb begin
      unique case (cmd.wsel)
         W_ZERO:   wdata = '0;
         W_PTR_T1: wdata = {FRAME_W'(t1_ff), PERM_W'(0), 1'b1};
         W_PTR_T2: wdata = {FRAME_W'(t2_ff), PERM_W'(0), 1'b1};
         W_LEAF:   wdata = {frame_ff, perms_ff, 1'b1};
         default:  wdata = '0;
      endcase
   end

   // Table memory, one access per cycle, registered read data.
   always_ff @(posedge clock) begin
      if (cmd.wr) mem[addr] <= wdata;
      if (cmd.rd) rd_data_ff <= mem[addr];
   end

   // Page allocation map updates.
   always_comb begin
      used_in = used_ff;
      if (cmd.alloc_t1 || cmd.alloc_t2) used_in[pg_ff] = 1'b1;
      if (cmd.free_t1 && t1_ff != '0) used_in[t1_ff] = 1'b0;
      if (cmd.free_t2 && t2_ff != '0) used_in[t2_ff] = 1'b0;
      if (cmd.free_child && ptr_ok) used_in[ptr_page] = 1'b0;
   end

   // Counters, page map and request capture.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= POOL_PAGES'(1);
         cnt_ff  <= '0;
         aux_ff  <= '0;
         pg_ff   <= PAGE_W'(1);
      end else begin
         used_ff <= used_in;
         if (cmd.cnt_clr)      cnt_ff <= '0;
         else if (cmd.cnt_inc) cnt_ff <= cnt_ff + IDX_W'(1);
         if (req_fire)         aux_ff <= '0;
         else if (cmd.aux_inc) aux_ff <= aux_ff + IDX_W'(1);
         if (cmd.pg_clr)       pg_ff <= PAGE_W'(1);
         else if (cmd.pg_inc)  pg_ff <= pg_ff + PAGE_W'(1);
      end
   end

   // Request fields and walk pointers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= op_type'(req_ch.op);
         vpn_ff   <= req_ch.vpn;
         frame_ff <= req_ch.frame;
         perms_ff <= req_ch.perms;
      end
      if (cmd.load_t1)       t1_ff <= ptr_ok ? ptr_page : '0;
      else if (cmd.alloc_t1) t1_ff <= pg_ff;
      if (cmd.load_t2)       t2_ff <= ptr_ok ? ptr_page : '0;
      else if (cmd.alloc_t2) t2_ff <= pg_ff;
   end

   // Response output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         if (op_ff == OP_LOOKUP && cmd.rsp_status == ST_OK) begin
            rsp_mapped_ff <= 1'b1;
            rsp_frame_ff  <= rd_frame;
            rsp_perms_ff  <= rd_data_ff[PERM_W:1];
         end else begin
            rsp_mapped_ff <= 1'b0;
            rsp_frame_ff  <= '0;
            rsp_perms_ff  <= '0;
         end
      end
   end

   assign req_ch.ready     = cmd.req_ready;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.status    = rsp_status_ff;
   assign rsp_ch.mapped    = rsp_mapped_ff;
   assign rsp_ch.frame_out = rsp_frame_ff;
   assign rsp_ch.perms_out = rsp_perms_ff;

   // Status toward the controller.
   always_comb begin
      stat.req_valid   = req_ch.valid;
      stat.op          = op_ff;
      stat.ptr_ok      = ptr_ok;
      stat.entry_valid = rd_data_ff[0];
      stat.page_free   = !used_ff[pg_ff];
      stat.pg_last     = (pg_ff == PAGE_W'(POOL_PAGES - 1));
      stat.cnt_last    = (cnt_ff == IDX_W'(ENTRIES - 1));
      stat.aux_last    = (aux_ff == IDX_W'(ENTRIES - 1));
      stat.slot_free   = !rsp_valid_ff || rsp_ch.ready;
   end

endmodule

// File: rtl/page_table_map_engine_unit.sv
`timescale 1ns / 1ps

// Three-level page table engine over a pool of POOL_PAGES table pages of 512
// entries, page 0 being the root. After reset the engine clears the root table
// before it takes the first transaction. Requests are handled one at a time
// and all table accesses go through one single-port table memory, one access
// per cycle. A lookup reads the root, middle and leaf entries in turn; a map
// into existing tables reads the root and middle entries and writes the leaf,
// and each table that a map allocates adds a free-page search over the pool
// and a clearing of the new table. An unmap that empties tables scans them
// entry by entry and frees them. A flush checks each root entry and, for
// each middle table present, frees its leaf tables and the middle table.
// The response sits in an output register, so a finished result may wait
// while the next request is accepted.
module page_table_map_engine_unit
   import ptme_pkg::*;
#(
   parameter int POOL_PAGES = POOL_PAGES_DEF
)
(
   input  logic       clock,
   input  logic       reset,
   ptme_req_if.sink   req_ch,
   ptme_rsp_if.source rsp_ch
);

   cmd_type  cmd;
   stat_type stat;

   ptme_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   ptme_dp #(
      .POOL_PAGES (POOL_PAGES)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .stat   (stat),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule
